// ===== hdl/anv_pkg.sv =====
package anv_pkg;

    localparam int NUM_GROUPS  = 16;
    localparam int GROUP_W     = 4;
    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 2 * SAMPLE_W;
    localparam int COUNT_W     = 13;
    localparam int SUM_W       = 29;
    localparam int SQ_W        = 43;
    localparam int MAX_SAMPLES = 4096;
    localparam int GUARD_BITS  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int F_W         = 40;
    localparam int DFB_W       = 4;
    localparam int DFW_W       = 13;
    localparam int STATUS_W    = 2;
    // between, grand, ssb, ssw all stay below 2^67 in units of 2^-24
    localparam int ACC_W       = 72;
    localparam int SQSUM_W     = SQ_W + GROUP_W;
    localparam int MAG_W       = SUM_W;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int NUMP_W      = 80;
    localparam int DIV_W       = 96;
    localparam int DIV_CNT_W   = 7;

    localparam logic [F_W-1:0] F_MAX = {F_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW_GROUP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_SSW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic                en;
        logic [GROUP_W-1:0]  group;
        logic [SAMPLE_W-1:0] sample;
        logic [SQUARE_W-1:0] square;
    } acc_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq;
    } cell_t;

endpackage

// ===== hdl/anv_if.sv =====
interface anv_in_if;
    logic                          valid;
    logic                          ready;
    logic [anv_pkg::SAMPLE_W-1:0]  sample;
    logic [anv_pkg::GROUP_W-1:0]   group;
    logic                          last;

    modport source (output valid, output sample, output group, output last, input ready);
    modport sink (input valid, input sample, input group, input last, output ready);
endinterface

interface anv_out_if;
    logic                          valid;
    logic                          ready;
    logic [anv_pkg::F_W-1:0]       f_value;
    logic [anv_pkg::DFB_W-1:0]     df_between;
    logic [anv_pkg::DFW_W-1:0]     df_within;
    logic [anv_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output f_value, output df_between, output df_within,
                    output status, input ready);
    modport sink (input valid, input f_value, input df_between, input df_within,
                  input status, output ready);
endinterface

// ===== hdl/anv_cell.sv =====
module anv_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [anv_pkg::GROUP_W-1:0] idx,
    input  anv_pkg::acc_t               acc,
    input  logic                        shift,
    input  anv_pkg::cell_t              neighbor,
    output anv_pkg::cell_t              data
);

    anv_pkg::cell_t data_reg;
    anv_pkg::cell_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = neighbor;
        end
        else if (acc.en && acc.group == idx)
        begin
            data_next.count = data_reg.count + 1'b1;
            data_next.sum   = data_reg.sum
                + {{(anv_pkg::SUM_W-anv_pkg::SAMPLE_W){acc.sample[anv_pkg::SAMPLE_W-1]}},
                   acc.sample};
            data_next.sq    = data_reg.sq
                + {{(anv_pkg::SQ_W-anv_pkg::SQUARE_W){1'b0}}, acc.square};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ===== hdl/anv_div.sv =====
module anv_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [anv_pkg::DIV_W-1:0] num,
    input  logic [anv_pkg::DIV_W-1:0] den,
    output logic                      busy,
    output logic                      done,
    output logic [anv_pkg::DIV_W-1:0] quot
);

    logic [anv_pkg::DIV_W-1:0]     rem_reg;
    logic [anv_pkg::DIV_W-1:0]     quo_reg;
    logic [anv_pkg::DIV_W-1:0]     den_reg;
    logic [anv_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [anv_pkg::DIV_W:0]       trial;
    logic [anv_pkg::DIV_W:0]       diff;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[anv_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[anv_pkg::DIV_W])
                begin
                    rem_reg <= diff[anv_pkg::DIV_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[anv_pkg::DIV_W-1:0];
                end
                quo_reg <= {quo_reg[anv_pkg::DIV_W-2:0], ~diff[anv_pkg::DIV_W]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == anv_pkg::DIV_CNT_W'(anv_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== hdl/one_way_anova_f_statistic_top.sv =====
// One-way ANOVA F statistic over a stream of labeled samples. Samples are taken one
// per cycle while idle; each lands in one of 16 group cells (count, sum, sum of
// squares) that form a shift chain. After the request marked last the input stalls
// while the chain drains into the reducer one cell at a time: an empty group is
// simply shifted out, a non-empty one waits for the serial divider that forms sum^2/n.
// The grand term and the final quotient each take one more divider pass, with a
// 13-step serial multiply between them. Draining also clears the cells. The result
// waits in an output register, and new samples are taken while it does.
module one_way_anova_f_statistic_top (
    input  logic        clk,
    input  logic        rst_n,
    anv_in_if.sink      in_ch,
    anv_out_if.source   out_ch
);

    typedef enum logic [3:0] {
        S_IDLE, S_GRP, S_SQ, S_DSTART, S_DWAIT, S_GRAND, S_SS, S_MUL, S_FLOAD, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_GROUP, PH_GRAND, PH_FINAL
    } phase_t;

    state_t state_reg;
    phase_t ph_reg;

    anv_pkg::acc_t  acc;
    anv_pkg::cell_t cell_q [anv_pkg::NUM_GROUPS];
    logic           shift;

    logic [anv_pkg::GROUP_W-1:0]  gcnt_reg;
    logic [anv_pkg::GROUP_W:0]    groups_reg;
    logic [anv_pkg::SQSUM_W-1:0]  sqsum_reg;
    logic [anv_pkg::ACC_W-1:0]    between_reg;
    logic [anv_pkg::ACC_W-1:0]    grand_reg;
    logic [anv_pkg::MAG_W-1:0]    mag_reg;
    logic [anv_pkg::COUNT_W-1:0]  den_reg;
    logic [anv_pkg::COUNT_W-1:0]  total_count_reg;
    logic [anv_pkg::SUM_W-1:0]    total_sum_reg;
    logic                         ovf_reg;
    logic [anv_pkg::NUMP_W-1:0]   mul_a_reg;
    logic [anv_pkg::ACC_W-1:0]    mul_b_reg;
    logic [anv_pkg::DFW_W-1:0]    dfw_sh_reg;
    logic [anv_pkg::DFB_W-1:0]    dfb_sh_reg;
    logic [anv_pkg::DFW_W-1:0]    mcnt_reg;
    logic [anv_pkg::NUMP_W-1:0]   num_acc_reg;
    logic [anv_pkg::ACC_W-1:0]    den_acc_reg;
    logic [anv_pkg::DFB_W-1:0]    dfb_reg;
    logic [anv_pkg::DFW_W-1:0]    dfw_reg;
    logic [anv_pkg::STATUS_W-1:0] status_reg;
    logic [anv_pkg::F_W-1:0]      f_reg;
    logic [anv_pkg::DIV_W-1:0]    div_num_reg;
    logic [anv_pkg::DIV_W-1:0]    div_den_reg;

    logic                         out_valid_reg;
    logic [anv_pkg::F_W-1:0]      out_f_reg;
    logic [anv_pkg::DFB_W-1:0]    out_dfb_reg;
    logic [anv_pkg::DFW_W-1:0]    out_dfw_reg;
    logic [anv_pkg::STATUS_W-1:0] out_status_reg;

    logic                         div_start;
    logic                         div_busy;
    logic                         div_done;
    logic [anv_pkg::DIV_W-1:0]    div_quot;

    logic                         in_acc;
    logic                         room;
    logic [anv_pkg::SAMPLE_W-1:0] smag;
    logic [anv_pkg::PROD_W-1:0]   sq_prod;
    logic [anv_pkg::MAG_W-1:0]    c0_mag;
    logic [anv_pkg::MAG_W-1:0]    tot_mag;
    logic [anv_pkg::ACC_W-1:0]    qs;
    logic [anv_pkg::ACC_W-1:0]    ssb;
    logic [anv_pkg::ACC_W-1:0]    ssw;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign room        = total_count_reg < anv_pkg::COUNT_W'(anv_pkg::MAX_SAMPLES);

    // magnitude of the sample, squared once and broadcast to the cells
    assign smag = in_ch.sample[anv_pkg::SAMPLE_W-1] ? (~in_ch.sample + 1'b1) : in_ch.sample;

    always_comb
    begin
        acc.en     = in_acc && room;
        acc.group  = in_ch.group;
        acc.sample = in_ch.sample;
        acc.square = smag * smag;
    end

    assign shift = (state_reg == S_GRP && cell_q[0].count == '0)
                || (state_reg == S_DWAIT && div_done && ph_reg == PH_GROUP);

    genvar gi;
    generate
        for (gi = 0; gi < anv_pkg::NUM_GROUPS; gi++)
        begin : g_cell
            anv_pkg::cell_t nb;
            if (gi == anv_pkg::NUM_GROUPS - 1)
            begin : g_end
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = cell_q[gi+1];
            end
            anv_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (anv_pkg::GROUP_W'(gi)),
                .acc      (acc),
                .shift    (shift),
                .neighbor (nb),
                .data     (cell_q[gi])
            );
        end
    endgenerate

    assign div_start = (state_reg == S_DSTART);

    anv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign sq_prod = mag_reg * mag_reg;
    assign c0_mag  = cell_q[0].sum[anv_pkg::SUM_W-1] ? (~cell_q[0].sum + 1'b1)
                                                     : cell_q[0].sum;
    assign tot_mag = total_sum_reg[anv_pkg::SUM_W-1] ? (~total_sum_reg + 1'b1)
                                                     : total_sum_reg;

    always_comb
    begin
        qs  = {{(anv_pkg::ACC_W-anv_pkg::SQSUM_W-anv_pkg::GUARD_BITS){1'b0}},
               sqsum_reg, {anv_pkg::GUARD_BITS{1'b0}}};
        ssb = (between_reg < grand_reg) ? '0 : (between_reg - grand_reg);
        ssw = (qs < between_reg) ? '0 : (qs - between_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ph_reg          <= PH_GROUP;
            total_count_reg <= '0;
            total_sum_reg   <= '0;
            ovf_reg         <= 1'b0;
            gcnt_reg        <= '0;
            groups_reg      <= '0;
            mcnt_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // in S_FIN the output register is handled below
            if (out_ch.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (room)
                        begin
                            total_count_reg <= total_count_reg + 1'b1;
                            total_sum_reg   <= total_sum_reg
                                + {{(anv_pkg::SUM_W-anv_pkg::SAMPLE_W)
                                    {in_ch.sample[anv_pkg::SAMPLE_W-1]}}, in_ch.sample};
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (in_ch.last)
                        begin
                            gcnt_reg    <= '0;
                            groups_reg  <= '0;
                            sqsum_reg   <= '0;
                            between_reg <= '0;
                            state_reg   <= S_GRP;
                        end
                    end
                end
                S_GRP:
                begin
                    if (cell_q[0].count == '0)
                    begin
                        gcnt_reg <= gcnt_reg + 1'b1;
                        if (gcnt_reg == anv_pkg::GROUP_W'(anv_pkg::NUM_GROUPS - 1))
                        begin
                            state_reg <= S_GRAND;
                        end
                    end
                    else
                    begin
                        groups_reg <= groups_reg + 1'b1;
                        sqsum_reg  <= sqsum_reg
                            + {{(anv_pkg::SQSUM_W-anv_pkg::SQ_W){1'b0}}, cell_q[0].sq};
                        mag_reg    <= c0_mag;
                        den_reg    <= cell_q[0].count;
                        ph_reg     <= PH_GROUP;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    div_num_reg <= {{(anv_pkg::DIV_W-anv_pkg::PROD_W-anv_pkg::GUARD_BITS){1'b0}},
                                    sq_prod, {anv_pkg::GUARD_BITS{1'b0}}};
                    div_den_reg <= {{(anv_pkg::DIV_W-anv_pkg::COUNT_W){1'b0}}, den_reg};
                    state_reg   <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        case (ph_reg)
                            PH_GROUP:
                            begin
                                between_reg <= between_reg + div_quot[anv_pkg::ACC_W-1:0];
                                gcnt_reg    <= gcnt_reg + 1'b1;
                                if (gcnt_reg == anv_pkg::GROUP_W'(anv_pkg::NUM_GROUPS - 1))
                                begin
                                    state_reg <= S_GRAND;
                                end
                                else
                                begin
                                    state_reg <= S_GRP;
                                end
                            end
                            PH_GRAND:
                            begin
                                grand_reg <= div_quot[anv_pkg::ACC_W-1:0];
                                state_reg <= S_SS;
                            end
                            default:
                            begin
                                if (div_quot > {{(anv_pkg::DIV_W-anv_pkg::F_W){1'b0}},
                                                anv_pkg::F_MAX})
                                begin
                                    f_reg <= anv_pkg::F_MAX;
                                end
                                else
                                begin
                                    f_reg <= div_quot[anv_pkg::F_W-1:0];
                                end
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_GRAND:
                begin
                    dfb_reg    <= (groups_reg == '0) ? '0
                                : anv_pkg::DFB_W'(groups_reg - 1'b1);
                    dfw_reg    <= total_count_reg
                                - {{(anv_pkg::DFW_W-anv_pkg::GROUP_W-1){1'b0}}, groups_reg};
                    f_reg      <= '0;
                    status_reg <= anv_pkg::ST_OK;
                    if (ovf_reg)
                    begin
                        status_reg <= anv_pkg::ST_OVERFLOW;
                        state_reg  <= S_FIN;
                    end
                    else if (groups_reg < 2)
                    begin
                        status_reg <= anv_pkg::ST_FEW_GROUP;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        mag_reg   <= tot_mag;
                        den_reg   <= total_count_reg;
                        ph_reg    <= PH_GRAND;
                        state_reg <= S_SQ;
                    end
                end
                S_SS:
                begin
                    if (dfw_reg == '0 || ssw == '0)
                    begin
                        status_reg <= anv_pkg::ST_ZERO_SSW;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        mul_a_reg   <= {{(anv_pkg::NUMP_W-anv_pkg::ACC_W){1'b0}}, ssb};
                        mul_b_reg   <= ssw;
                        dfw_sh_reg  <= dfw_reg;
                        dfb_sh_reg  <= dfb_reg;
                        num_acc_reg <= '0;
                        den_acc_reg <= '0;
                        mcnt_reg    <= '0;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // shift-add products ssb*df_within and ssw*df_between
                    if (dfw_sh_reg[0])
                    begin
                        num_acc_reg <= num_acc_reg + mul_a_reg;
                    end
                    if (dfb_sh_reg[0])
                    begin
                        den_acc_reg <= den_acc_reg + mul_b_reg;
                    end
                    mul_a_reg  <= {mul_a_reg[anv_pkg::NUMP_W-2:0], 1'b0};
                    mul_b_reg  <= {mul_b_reg[anv_pkg::ACC_W-2:0], 1'b0};
                    dfw_sh_reg <= {1'b0, dfw_sh_reg[anv_pkg::DFW_W-1:1]};
                    dfb_sh_reg <= {1'b0, dfb_sh_reg[anv_pkg::DFB_W-1:1]};
                    mcnt_reg   <= mcnt_reg + 1'b1;
                    if (mcnt_reg == anv_pkg::DFW_W'(anv_pkg::DFW_W - 1))
                    begin
                        state_reg <= S_FLOAD;
                    end
                end
                S_FLOAD:
                begin
                    div_num_reg <= {num_acc_reg, {anv_pkg::FRAC_BITS{1'b0}}};
                    div_den_reg <= {{(anv_pkg::DIV_W-anv_pkg::ACC_W){1'b0}}, den_acc_reg};
                    ph_reg      <= PH_FINAL;
                    state_reg   <= S_DSTART;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_f_reg       <= f_reg;
                        out_dfb_reg     <= dfb_reg;
                        out_dfw_reg     <= dfw_reg;
                        out_status_reg  <= status_reg;
                        total_count_reg <= '0;
                        total_sum_reg   <= '0;
                        ovf_reg         <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.f_value    = out_f_reg;
    assign out_ch.df_between = out_dfb_reg;
    assign out_ch.df_within  = out_dfw_reg;
    assign out_ch.status     = out_status_reg;

`ifndef NO_ASSERTIONS
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.last) |=> !in_ch.ready)
        else $error("input not stalled after last request");

    a_err_zero_f: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != anv_pkg::ST_OK) |-> (out_f_reg == '0))
        else $error("nonzero f_value with error status");

    a_ok_has_groups: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == anv_pkg::ST_OK) |-> (out_dfb_reg != '0))
        else $error("ok status with fewer than two groups");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

// ===== tb/one_way_anova_f_statistic_top_tb.sv =====
`timescale 1ns / 1ps

module one_way_anova_f_statistic_top_tb;

    typedef struct {
        logic [anv_pkg::F_W-1:0]      f_value;
        logic [anv_pkg::DFB_W-1:0]    df_between;
        logic [anv_pkg::DFW_W-1:0]    df_within;
        logic [anv_pkg::STATUS_W-1:0] status;
    } anova_result_t;

    class anova_scoreboard;
        int unsigned   grp_n [anv_pkg::NUM_GROUPS];
        longint        grp_sum [anv_pkg::NUM_GROUPS];
        longint        grp_sq [anv_pkg::NUM_GROUPS];
        longint        all_sum;
        int unsigned   all_n;
        bit            too_many;
        anova_result_t expected_q [$];
        int            mismatches;

        function void clear_sums();
            foreach (grp_n[i])
            begin
                grp_n[i] = 0;
                grp_sum[i] = 0;
                grp_sq[i] = 0;
            end
            all_sum = 0;
            all_n = 0;
            too_many = 0;
        endfunction

        // floor(s^2 * 2^24 / n)
        function logic [127:0] square_per_count(longint s, int unsigned n);
            logic [127:0] m;
            m = (s < 0) ? 128'(-s) : 128'(s);
            return ((m * m) << anv_pkg::GUARD_BITS) / 128'(n);
        endfunction

        function void note_request(logic [anv_pkg::SAMPLE_W-1:0] sample,
                                   logic [anv_pkg::GROUP_W-1:0] group, logic last);
            longint        x;
            logic [127:0]  between, grand, qs, ssb, ssw, fq;
            longint        sq_total;
            int unsigned   groups, dfb, dfw;
            anova_result_t r;
            x = longint'($signed(sample));
            between = 0;
            sq_total = 0;
            groups = 0;
            if (all_n >= anv_pkg::MAX_SAMPLES)
                too_many = 1;
            else
            begin
                grp_n[group]++;
                grp_sum[group] += x;
                grp_sq[group] += x * x;
                all_sum += x;
                all_n++;
            end
            if (!last)
                return;
            for (int i = 0; i < anv_pkg::NUM_GROUPS; i++)
            begin
                if (grp_n[i] != 0)
                begin
                    groups++;
                    sq_total += grp_sq[i];
                    between += square_per_count(grp_sum[i], grp_n[i]);
                end
            end
            dfb = (groups > 0) ? groups - 1 : 0;
            dfw = all_n - groups;
            r.f_value = 0;
            r.df_between = dfb[anv_pkg::DFB_W-1:0];
            r.df_within = dfw[anv_pkg::DFW_W-1:0];
            if (too_many)
                r.status = anv_pkg::ST_OVERFLOW;
            else if (groups < 2)
                r.status = anv_pkg::ST_FEW_GROUP;
            else
            begin
                grand = square_per_count(all_sum, all_n);
                qs = 128'(sq_total) << anv_pkg::GUARD_BITS;
                ssb = (between < grand) ? 128'd0 : between - grand;
                ssw = (qs < between) ? 128'd0 : qs - between;
                if (dfw == 0 || ssw == 0)
                    r.status = anv_pkg::ST_ZERO_SSW;
                else
                begin
                    r.status = anv_pkg::ST_OK;
                    fq = ((ssb * 128'(dfw)) << anv_pkg::FRAC_BITS) / (ssw * 128'(dfb));
                    r.f_value = (fq > 128'(anv_pkg::F_MAX)) ? anv_pkg::F_MAX
                                                            : fq[anv_pkg::F_W-1:0];
                end
            end
            expected_q = {expected_q, r};
            clear_sums();
        endfunction

        function void check_result(anova_result_t got);
            anova_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: f_value %0d status %0d",
                       got.f_value, got.status);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (got.f_value !== e.f_value)
            begin
                $error("f_value expected %0d actual %0d", e.f_value, got.f_value);
                mismatches++;
            end
            if (got.df_between !== e.df_between)
            begin
                $error("df_between expected %0d actual %0d", e.df_between, got.df_between);
                mismatches++;
            end
            if (got.df_within !== e.df_within)
            begin
                $error("df_within expected %0d actual %0d", e.df_within, got.df_within);
                mismatches++;
            end
            if (got.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 40000;

    logic clk;
    logic rst_n;
    anv_in_if  in_ch ();
    anv_out_if out_ch ();

    anova_scoreboard scoreboard;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned quiet_cycles;
    int unsigned items_sent;

    one_way_anova_f_statistic_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        scoreboard = new();
        scoreboard.clear_sums();
        scoreboard.mismatches = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        quiet_cycles = 0;
        items_sent = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.group = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // monitors, receiver stalls and watchdog
    always @(posedge clk)
    begin
        anova_result_t got;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                scoreboard.note_request(in_ch.sample, in_ch.group, in_ch.last);
            if (out_ch.valid && out_ch.ready)
            begin
                got.f_value = out_ch.f_value;
                got.df_between = out_ch.df_between;
                got.df_within = out_ch.df_within;
                got.status = out_ch.status;
                scoreboard.check_result(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_sample(input logic [anv_pkg::SAMPLE_W-1:0] sample,
                               input logic [anv_pkg::GROUP_W-1:0] group, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample <= sample;
        in_ch.group <= group;
        in_ch.last <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // a well-formed data set with random content, sized by len
    task automatic send_random_set(input int unsigned len);
        int unsigned labels;
        int unsigned base;
        int unsigned style;
        int          spread;
        logic [anv_pkg::GROUP_W-1:0]  g;
        logic [anv_pkg::SAMPLE_W-1:0] s;
        labels = $urandom_range(1, anv_pkg::NUM_GROUPS);
        base = $urandom_range(anv_pkg::NUM_GROUPS - 1);
        style = $urandom_range(9);
        spread = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            g = anv_pkg::GROUP_W'((base + $urandom_range(labels - 1)) % anv_pkg::NUM_GROUPS);
            if (style < 4)
                s = anv_pkg::SAMPLE_W'($urandom);
            else if (style < 7)
                s = anv_pkg::SAMPLE_W'(int'(g) * 1000 - 8000
                                       + int'($urandom_range(2 * spread)) - spread);
            else if (style < 8)
                s = anv_pkg::SAMPLE_W'(int'(g) * 300);   // constant per group, zero within spread
            else
                s = anv_pkg::SAMPLE_W'(int'($urandom_range(2 * spread)) - spread);
            send_sample(s, g, i == len - 1);
        end
    endtask

    initial
    begin
        int unsigned len;
        @(posedge rst_n);
        @(posedge clk);

        // single sample, one group
        send_sample(16'h8000, 4'd0, 1'b1);
        // one sample per group: no within freedom
        send_sample(16'h7fff, 4'd15, 1'b0);
        send_sample(16'h8000, 4'd0, 1'b1);
        // constant groups: zero within sum of squares
        send_sample(16'd5, 4'd1, 1'b0);
        send_sample(16'd5, 4'd1, 1'b0);
        send_sample(16'd7, 4'd2, 1'b0);
        send_sample(16'd7, 4'd2, 1'b1);
        // far apart groups with tiny spread: saturates
        for (int i = 0; i < 5; i++)
            send_sample((i == 4) ? 16'h8001 : 16'h8000, 4'd0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_sample(16'h7fff, 4'd3, i == 4);
        // ordinary three-group set
        send_sample(16'd10, 4'd4, 1'b0);
        send_sample(16'd12, 4'd4, 1'b0);
        send_sample(16'hfff0, 4'd8, 1'b0);
        send_sample(16'hffee, 4'd8, 1'b0);
        send_sample(16'd0, 4'd12, 1'b0);
        send_sample(16'd3, 4'd12, 1'b1);
        drain_results();

        while (items_sent < 1650)
        begin
            case ((items_sent / 150) % 5)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
                3: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            len = ($urandom_range(19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
            send_random_set(len);
            if ($urandom_range(15) == 0)
                drain_results();
        end
        drain_results();
        repeat (50) @(posedge clk);
        if (scoreboard.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
